### hdl/dcd_pkg.sv
// Shared types, codes and constants of the debounced door controller.
// Used by dcd_debounce, dcd_fsm and door_controller_with_debounce; no dependencies.
package dcd_pkg;

    localparam int NumInputs  = 5;
    localparam int CountW     = 8;
    localparam int StateCodeW = 4;
    localparam int MotorW     = 2;
    localparam int CfgIndexW  = 1;
    localparam int InTdataW   = 8;
    localparam int OutTdataW  = 16;
    localparam int ResultW    = StateCodeW + 3 + MotorW;

    localparam logic [CountW-1:0] PressThresholdReset = 8'd30;
    localparam logic [CountW-1:0] DebounceLimitReset  = 8'd50;

    typedef enum logic [CfgIndexW-1:0] {
        CFG_PRESS_THRESHOLD = 1'b0,
        CFG_DEBOUNCE_LIMIT  = 1'b1
    } cfg_index_t;

    // One bit per input, open button in bit 0, emergency in bit 4.
    typedef struct packed {
        logic emergency;
        logic close_limit;
        logic open_limit;
        logic close_button;
        logic open_button;
    } press_t;

    typedef enum logic [8:0] {
        ST_LOCKED  = 9'b0_0000_0001,
        ST_ONE     = 9'b0_0000_0010,
        ST_TWO     = 9'b0_0000_0100,
        ST_THREE   = 9'b0_0000_1000,
        ST_IDLE    = 9'b0_0001_0000,
        ST_CLOSED  = 9'b0_0010_0000,
        ST_OPENING = 9'b0_0100_0000,
        ST_OPEN    = 9'b0_1000_0000,
        ST_CLOSING = 9'b1_0000_0000
    } door_state_t;

    localparam logic [StateCodeW-1:0] CODE_LOCKED  = 4'd0;
    localparam logic [StateCodeW-1:0] CODE_ONE     = 4'd1;
    localparam logic [StateCodeW-1:0] CODE_TWO     = 4'd2;
    localparam logic [StateCodeW-1:0] CODE_THREE   = 4'd3;
    localparam logic [StateCodeW-1:0] CODE_IDLE    = 4'd4;
    localparam logic [StateCodeW-1:0] CODE_CLOSED  = 4'd5;
    localparam logic [StateCodeW-1:0] CODE_OPENING = 4'd6;
    localparam logic [StateCodeW-1:0] CODE_OPEN    = 4'd7;
    localparam logic [StateCodeW-1:0] CODE_CLOSING = 4'd8;

    typedef enum logic [MotorW-1:0] {
        MOTOR_STOP  = 2'd0,
        MOTOR_OPEN  = 2'd1,
        MOTOR_CLOSE = 2'd2
    } motor_t;

    typedef struct packed {
        logic lock_lamp;
        logic close_lamp;
        logic open_lamp;
    } lamp_t;

    // Result fields, door state code in the lowest bits.
    typedef struct packed {
        logic [MotorW-1:0]     motor_command;
        logic                  lock_lamp;
        logic                  close_lamp;
        logic                  open_lamp;
        logic [StateCodeW-1:0] door_state_code;
    } result_t;

    function automatic logic [StateCodeW-1:0] state_code(door_state_t s);
        logic [StateCodeW-1:0] code;
        unique case (s)
            ST_LOCKED:  code = CODE_LOCKED;
            ST_ONE:     code = CODE_ONE;
            ST_TWO:     code = CODE_TWO;
            ST_THREE:   code = CODE_THREE;
            ST_IDLE:    code = CODE_IDLE;
            ST_CLOSED:  code = CODE_CLOSED;
            ST_OPENING: code = CODE_OPENING;
            ST_OPEN:    code = CODE_OPEN;
            ST_CLOSING: code = CODE_CLOSING;
            default:    code = CODE_LOCKED;
        endcase
        return code;
    endfunction

endpackage

### hdl/dcd_debounce.sv
// Five saturating debounce counters and the pressed decision per input.
// Depends on dcd_pkg.
module dcd_debounce (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  dcd_pkg::press_t               levels,
    input  logic [dcd_pkg::CountW-1:0]    press_threshold,
    input  logic [dcd_pkg::CountW-1:0]    debounce_limit,
    output dcd_pkg::press_t               pressed
);
    import dcd_pkg::*;

    logic [CountW-1:0]    cnt_reg  [NumInputs];
    logic [CountW-1:0]    cnt_next [NumInputs];
    logic [NumInputs-1:0] lvl;
    logic [NumInputs-1:0] press_v;

    assign lvl     = levels;
    assign pressed = press_t'(press_v);

    // Counters rise while the level is low (clamped to the ceiling) and fall while high.
    always_comb begin
        for (int i = 0; i < NumInputs; i++) begin
            if (!lvl[i]) begin
                if (cnt_reg[i] >= debounce_limit) begin
                    cnt_next[i] = debounce_limit;
                end else begin
                    cnt_next[i] = CountW'(cnt_reg[i] + 1'b1);
                end
            end else if (cnt_reg[i] != '0) begin
                cnt_next[i] = CountW'(cnt_reg[i] - 1'b1);
            end else begin
                cnt_next[i] = cnt_reg[i];
            end
            press_v[i] = !lvl[i] && (cnt_next[i] > press_threshold);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NumInputs; i++) begin
                cnt_reg[i] <= '0;
            end
        end else if (advance) begin
            for (int i = 0; i < NumInputs; i++) begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

    for (genvar g = 0; g < NumInputs; g++) begin : g_chk
        a_low_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
            advance && !lvl[g] |=> cnt_reg[g] <= $past(debounce_limit))
            else $error("debounce counter rose above the ceiling");
    end

endmodule

### hdl/dcd_fsm.sv
// Door state machine: unlock sequence and door movement, lamps and motor drive.
// Depends on dcd_pkg.
module dcd_fsm (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  dcd_pkg::press_t   pressed,
    output dcd_pkg::result_t  step_result
);
    import dcd_pkg::*;

    door_state_t state_reg, state_next;
    lamp_t       lamp_reg, lamp_next;
    motor_t      motor_reg, motor_next;

    // Checks within a state are in order; a later one overrides an earlier one.
    always_comb begin
        state_next = state_reg;
        lamp_next  = lamp_reg;
        motor_next = motor_reg;
        unique case (state_reg)
            ST_LOCKED: begin
                lamp_next  = '{lock_lamp: 1'b1, close_lamp: 1'b1, open_lamp: 1'b1};
                motor_next = MOTOR_STOP;
                if (pressed.open_button) state_next = ST_ONE;
            end
            ST_ONE: begin
                lamp_next = '{lock_lamp: 1'b0, close_lamp: 1'b0, open_lamp: 1'b1};
                if (pressed.close_button) state_next = ST_TWO;
            end
            ST_TWO: begin
                lamp_next = '{lock_lamp: 1'b0, close_lamp: 1'b1, open_lamp: 1'b0};
                if (pressed.open_button) state_next = ST_THREE;
            end
            ST_THREE: begin
                lamp_next = '{lock_lamp: 1'b1, close_lamp: 1'b0, open_lamp: 1'b0};
                if (pressed.emergency) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                lamp_next = '{lock_lamp: 1'b1, close_lamp: 1'b0, open_lamp: 1'b1};
                if (pressed.open_limit)  state_next = ST_OPEN;
                if (pressed.close_limit) state_next = ST_CLOSED;
                if (pressed.open_button) state_next = ST_OPENING;
                if (pressed.close_button) begin
                    lamp_next.open_lamp = 1'b0;
                    state_next          = ST_CLOSING;
                end
            end
            ST_CLOSED: begin
                lamp_next = '{lock_lamp: 1'b0, close_lamp: 1'b1, open_lamp: 1'b0};
                if (pressed.open_button) begin
                    lamp_next.close_lamp = 1'b0;
                    state_next           = ST_OPENING;
                end
                if (pressed.emergency) state_next = ST_LOCKED;
            end
            ST_OPENING: begin
                motor_next = MOTOR_OPEN;
                if (pressed.emergency)    state_next = ST_LOCKED;
                if (pressed.close_button) state_next = ST_CLOSING;
                if (pressed.open_limit) begin
                    motor_next = MOTOR_STOP;
                    state_next = ST_OPEN;
                end
            end
            ST_OPEN: begin
                lamp_next = '{lock_lamp: 1'b0, close_lamp: 1'b0, open_lamp: 1'b1};
                if (pressed.close_button) begin
                    lamp_next.open_lamp = 1'b0;
                    state_next          = ST_CLOSING;
                end
                if (pressed.emergency) state_next = ST_LOCKED;
            end
            ST_CLOSING: begin
                motor_next = MOTOR_CLOSE;
                if (pressed.emergency)   state_next = ST_LOCKED;
                if (pressed.open_button) state_next = ST_OPENING;
                if (pressed.close_limit) begin
                    motor_next = MOTOR_STOP;
                    state_next = ST_CLOSED;
                end
            end
            default: begin
                state_next = state_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOCKED;
            lamp_reg  <= '0;
            motor_reg <= MOTOR_STOP;
        end else if (advance) begin
            state_reg <= state_next;
            lamp_reg  <= lamp_next;
            motor_reg <= motor_next;
        end
    end

    assign step_result.door_state_code = state_code(state_next);
    assign step_result.open_lamp       = lamp_next.open_lamp;
    assign step_result.close_lamp      = lamp_next.close_lamp;
    assign step_result.lock_lamp       = lamp_next.lock_lamp;
    assign step_result.motor_command   = motor_next;

    a_locked_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && state_reg == ST_LOCKED |=> motor_reg == MOTOR_STOP)
        else $error("motor still driven after a locked step");

    a_motor_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && motor_next == MOTOR_CLOSE |->
        state_next == ST_CLOSING || state_next == ST_LOCKED || state_next == ST_OPENING
        || state_reg != ST_CLOSING)
        else $error("closing drive left on in an unexpected state");

endmodule

### hdl/door_controller_with_debounce.sv
// Top level of the debounced door controller: stream channels, configuration and pipeline.
// Depends on dcd_pkg, dcd_debounce and dcd_fsm.
//
// Usage. Each request on the s_ channel is one debounce tick carrying five active-low
// levels (open button, close button, open limit, close limit, emergency). Every request
// produces exactly one result request on the m_ channel: the door state code after the
// tick, the three indicator lamps and the motor command.
// The configuration channel writes the press threshold (index 0) and the debounce
// ceiling (index 1); it is always ready and should only be used while the block is idle.
// Path: an accepted tick is registered in the input register, then processed through the
// debounce counters and state machine into the output register, which drives m_tvalid.
// Throughput is one tick per cycle while the receiver does not stall; the loop through
// the debounce counters and the state register sets that figure.
// Reset (aresetn low, synchronous) clears the counters, restores the default threshold
// of 30 and ceiling of 50, puts the door in the locked state with lamps off and the
// motor stopped, and empties both pipeline stages.
// When the receiver stalls, the result holds on m_tdata and one further tick can still be
// taken into the input register; s_tready falls only when both stages are full.
module door_controller_with_debounce (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // bit 0 open_button_level, 1 close_button_level, 2 open_limit_level,
    // 3 close_limit_level, 4 emergency_level, 7:5 zero
    input  logic [dcd_pkg::InTdataW-1:0]      s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // bits 3:0 door_state_code, 4 open_lamp, 5 close_lamp, 6 lock_lamp,
    // 8:7 motor_command, 15:9 zero
    output logic [dcd_pkg::OutTdataW-1:0]     m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dcd_pkg::CfgIndexW-1:0]     cfg_index,
    input  logic [dcd_pkg::CountW-1:0]        cfg_data
);
    import dcd_pkg::*;

    logic              in_valid_reg;
    press_t            in_level_reg;
    logic              out_valid_reg;
    result_t           out_data_reg;
    logic [CountW-1:0] threshold_reg;
    logic [CountW-1:0] limit_reg;
    logic              advance;
    press_t            pressed;
    result_t           step_result;

    // The processing stage moves on whenever it holds a tick and the output register is empty or being emptied.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(OutTdataW - ResultW){1'b0}}, out_data_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= PressThresholdReset;
            limit_reg     <= DebounceLimitReset;
        end else if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PRESS_THRESHOLD: threshold_reg <= cfg_data;
                CFG_DEBOUNCE_LIMIT:  limit_reg     <= cfg_data;
                default:             threshold_reg <= threshold_reg;
            endcase
        end
    end

    // Input register: taken whenever it is free or its tick moves on this cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_level_reg <= press_t'(s_tdata[NumInputs-1:0]);
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= step_result;
        end
    end

    dcd_debounce u_debounce (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .advance         (advance),
        .levels          (in_level_reg),
        .press_threshold (threshold_reg),
        .debounce_limit  (limit_reg),
        .pressed         (pressed)
    );

    dcd_fsm u_fsm (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .pressed     (pressed),
        .step_result (step_result)
    );

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_level_reg))
        else $error("held tick lost from the input register");

endmodule
